// File: hw/rtl/psqrl_pkg.sv
package psqrl_pkg;

   localparam int Entries = 32;
   localparam int IdxW    = $clog2(Entries);
   localparam int FloorQ  = (Entries * 3) / 4;
   localparam int DivW    = 32;
   localparam int DsrW    = 16;
   localparam int CntW    = $clog2(DivW + 1);
   localparam int DecW    = 23;

   localparam logic [15:0] Sat16   = 16'hFFFF;

   // floor(x / 125) = (x * MsRecip) >> MsShift for any x below 2^29
   localparam logic [29:0] MsRecip = 30'd549755814;
   localparam int          MsShift = 36;

   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_BAN     = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [2:0] REG_ENABLE    = 3'd0;
   localparam logic [2:0] REG_BAN_TIME  = 3'd1;
   localparam logic [2:0] REG_BAN_LEVEL = 3'd2;
   localparam logic [2:0] REG_LP_MAX    = 3'd3;
   localparam logic [2:0] REG_HP_MAX    = 3'd4;
   localparam logic [2:0] REG_HP_MIN    = 3'd5;
   localparam logic [2:0] REG_UNIQ_MAX  = 3'd6;
   localparam logic [2:0] REG_TOTAL_MAX = 3'd7;

   typedef enum logic [1:0] {
      CMD_CHECK = 2'd0,
      CMD_COUNT = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_OTHER = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISP, ST_UPD, ST_STAT, ST_TINIT, ST_TDEC,
      ST_TRD, ST_TENT, ST_TDIV, ST_TAPP, ST_TFIN
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] src_ip;
      logic        critical;
      logic [15:0] delta_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        allow;
      logic [31:0] ban_ip;
      logic [25:0] ban_pps;
      logic        global_limit;
      logic        under_flood;
      logic        global_query_ok;
      logic        last;
   } rsp_type;

   typedef struct packed {
      cmd_type     op;
      logic [31:0] src_ip;
      logic        critical;
      logic [15:0] delta_ms;
   } job_type;

   typedef struct packed {
      logic        limiter_enable;
      logic [15:0] ban_time_s;
      logic [15:0] ban_level_pps;
      logic [15:0] low_prio_rate_max;
      logic [15:0] high_prio_rate_max;
      logic [15:0] high_prio_rate_min;
      logic [15:0] unique_filter_max;
      logic [15:0] total_filter_max;
   } cfg_type;

endpackage

// File: hw/rtl/psqrl_front.sv
module psqrl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  psqrl_pkg::req_type req_data,
   output logic               job_valid,
   input  logic               job_pop,
   output psqrl_pkg::job_type job
);

   psqrl_pkg::job_type q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   psqrl_pkg::job_type cls;

   // classify the incoming transaction
   always_comb begin
      cls.op       = psqrl_pkg::cmd_type'(req_data.cmd);
      cls.src_ip   = req_data.src_ip;
      cls.critical = req_data.critical;
      cls.delta_ms = req_data.delta_ms;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = job_pop && job_valid;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold queued jobs
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

// File: hw/rtl/psqrl_div.sv
module psqrl_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [psqrl_pkg::DivW-1:0] dividend,
   input  logic [psqrl_pkg::DsrW-1:0] divisor,
   output logic                       busy,
   output logic [psqrl_pkg::DivW-1:0] quotient
);

   logic [psqrl_pkg::DivW-1:0] quo_ff, quo_in;
   logic [psqrl_pkg::DsrW-1:0] rem_ff, rem_in;
   logic [psqrl_pkg::DsrW-1:0] dsr_ff, dsr_in;
   logic [psqrl_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [psqrl_pkg::DsrW:0]   rem_sh;
   logic                       ge;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // one restoring step per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[psqrl_pkg::DivW-1]};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = psqrl_pkg::CntW'(psqrl_pkg::DivW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? psqrl_pkg::DsrW'(rem_sh - {1'b0, dsr_ff})
                      : psqrl_pkg::DsrW'(rem_sh);
         quo_in  = {quo_ff[psqrl_pkg::DivW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != psqrl_pkg::CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

endmodule

// File: hw/rtl/psqrl_back.sv
module psqrl_back (
   input  logic               clock,
   input  logic               reset,
   input  psqrl_pkg::cfg_type cfg,
   input  logic               job_valid,
   output logic               job_pop,
   input  psqrl_pkg::job_type job,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output psqrl_pkg::rsp_type rsp_data
);

   localparam logic [psqrl_pkg::IdxW-1:0] LastIdx = psqrl_pkg::IdxW'(psqrl_pkg::Entries - 1);

   psqrl_pkg::state_type state_ff, state_in;

   logic [31:0] addr_ff [psqrl_pkg::Entries];
   logic [15:0] rate_ff [psqrl_pkg::Entries];
   logic [psqrl_pkg::IdxW-1:0] ptr_ff, hidx_ff, walk_ff, rd_idx, match_idx;
   logic [15:0] uniq_ff, total_ff, rd_rate_ff;
   logic        glob_ff, hit_ff, allow_ff, match_hit;
   logic [1:0]  kind_ff;
   logic [psqrl_pkg::DecW-1:0] dec_ff;
   logic [31:0] prod_ff;
   logic [58:0] dec_prod;
   psqrl_pkg::job_type job_ff;

   // output queue
   psqrl_pkg::rsp_type oq_ff [2];
   logic       owr_ff, ord_ff;
   logic [1:0] ocnt_ff;
   logic       out_full, out_push, do_opop;
   psqrl_pkg::rsp_type out_data;

   // divider hookup
   logic        div_start, div_busy;
   logic [31:0] div_dividend, div_quo;
   logic [15:0] div_divisor, deff;

   // per-entry tick terms
   logic [25:0] pps;
   logic        ban;
   logic [15:0] decayed, lo, diff;

   assign deff = (job_ff.delta_ms == 16'd0) ? 16'd1 : job_ff.delta_ms;

   // search the table, lowest index wins
   always_comb begin
      match_hit = 1'b0;
      match_idx = '0;
      for (int i = psqrl_pkg::Entries - 1; i >= 0; i--) begin
         if (addr_ff[i] == job_ff.src_ip) begin
            match_hit = 1'b1;
            match_idx = psqrl_pkg::IdxW'(i);
         end
      end
   end

   assign rd_idx = (state_ff == psqrl_pkg::ST_DISP) ? match_idx : walk_ff;

   // ban and decay terms for the walked entry
   always_comb begin
      pps  = div_quo[25:0];
      ban  = (cfg.ban_time_s != 16'd0) && (pps > {10'd0, cfg.ban_level_pps});
      lo   = {1'b0, cfg.low_prio_rate_max[15:1]};
      diff = rd_rate_ff - dec_ff[15:0];
      if ({1'b0, rd_rate_ff} <= {cfg.low_prio_rate_max, 1'b0}) begin
         decayed = 16'd0;
      end else if (dec_ff >= {7'd0, rd_rate_ff}) begin
         decayed = lo;
      end else begin
         decayed = (diff > lo) ? diff : lo;
      end
   end

   // decay per tick: floor(level * delta / 1000) taken as floor((p / 8) / 125)
   assign dec_prod = {30'd0, prod_ff[31:3]} * {29'd0, psqrl_pkg::MsRecip};

   // divider operands: pps of the walked entry
   assign div_dividend = {16'd0, rd_rate_ff} * 32'd1000;
   assign div_divisor  = deff;

   psqrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psqrl_pkg::ST_IDLE:  if (job_valid) state_in = psqrl_pkg::ST_DISP;
         psqrl_pkg::ST_DISP: begin
            case (job_ff.op)
               psqrl_pkg::CMD_CHECK: state_in = cfg.limiter_enable ? psqrl_pkg::ST_UPD
                                                                  : psqrl_pkg::ST_STAT;
               psqrl_pkg::CMD_TICK:  state_in = psqrl_pkg::ST_TINIT;
               default:              state_in = psqrl_pkg::ST_STAT;
            endcase
         end
         psqrl_pkg::ST_UPD:   state_in = psqrl_pkg::ST_STAT;
         psqrl_pkg::ST_STAT:  if (!out_full) state_in = psqrl_pkg::ST_IDLE;
         psqrl_pkg::ST_TINIT: state_in = psqrl_pkg::ST_TDEC;
         psqrl_pkg::ST_TDEC:  state_in = psqrl_pkg::ST_TRD;
         psqrl_pkg::ST_TRD:   state_in = psqrl_pkg::ST_TENT;
         psqrl_pkg::ST_TENT: begin
            if (rd_rate_ff != 16'd0) begin
               state_in = psqrl_pkg::ST_TDIV;
            end else begin
               state_in = (walk_ff == LastIdx) ? psqrl_pkg::ST_TFIN : psqrl_pkg::ST_TRD;
            end
         end
         psqrl_pkg::ST_TDIV:  if (!div_busy) state_in = psqrl_pkg::ST_TAPP;
         psqrl_pkg::ST_TAPP: begin
            if (!(ban && out_full)) begin
               state_in = (walk_ff == LastIdx) ? psqrl_pkg::ST_TFIN : psqrl_pkg::ST_TRD;
            end
         end
         psqrl_pkg::ST_TFIN:  state_in = psqrl_pkg::ST_STAT;
         default:             state_in = psqrl_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      job_pop   = 1'b0;
      div_start = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;
      case (state_ff)
         psqrl_pkg::ST_IDLE:  job_pop = job_valid;
         psqrl_pkg::ST_TENT:  div_start = (rd_rate_ff != 16'd0);
         psqrl_pkg::ST_TAPP: begin
            out_push         = ban && !out_full;
            out_data.kind    = psqrl_pkg::KIND_BAN;
            out_data.ban_ip  = addr_ff[walk_ff];
            out_data.ban_pps = pps;
         end
         psqrl_pkg::ST_STAT: begin
            out_push                 = !out_full;
            out_data.kind            = kind_ff;
            out_data.allow           = allow_ff;
            out_data.global_limit    = glob_ff;
            out_data.under_flood     = (uniq_ff >= 16'(psqrl_pkg::Entries));
            out_data.global_query_ok = (total_ff < 16'(psqrl_pkg::Entries));
            out_data.last            = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psqrl_pkg::ST_IDLE;
         ptr_ff   <= LastIdx;
         uniq_ff  <= 16'd0;
         total_ff <= 16'd0;
         glob_ff  <= 1'b0;
         walk_ff  <= '0;
         for (int i = 0; i < psqrl_pkg::Entries; i++) begin
            addr_ff[i] <= 32'd0;
            rate_ff[i] <= 16'd0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            psqrl_pkg::ST_DISP: begin
               if (job_ff.op == psqrl_pkg::CMD_COUNT && total_ff != psqrl_pkg::Sat16) begin
                  total_ff <= total_ff + 16'd1;
               end
            end
            psqrl_pkg::ST_UPD: begin
               if (hit_ff) begin
                  if (job_ff.critical && rd_rate_ff < cfg.high_prio_rate_min) begin
                     rate_ff[hidx_ff] <= cfg.high_prio_rate_min;
                  end else if (rd_rate_ff != psqrl_pkg::Sat16) begin
                     rate_ff[hidx_ff] <= rd_rate_ff + 16'd1;
                  end
               end else begin
                  if (uniq_ff != psqrl_pkg::Sat16) uniq_ff <= uniq_ff + 16'd1;
                  if (uniq_ff >= 16'(psqrl_pkg::Entries)) begin
                     glob_ff <= ((uniq_ff == psqrl_pkg::Sat16 ? uniq_ff : uniq_ff + 16'd1)
                                 > cfg.unique_filter_max)
                             || (total_ff > cfg.total_filter_max);
                  end else begin
                     ptr_ff <= (ptr_ff == LastIdx) ? '0 : ptr_ff + 1'b1;
                     addr_ff[(ptr_ff == LastIdx) ? '0 : ptr_ff + 1'b1] <= job_ff.src_ip;
                     rate_ff[(ptr_ff == LastIdx) ? '0 : ptr_ff + 1'b1] <= 16'd1;
                  end
               end
            end
            psqrl_pkg::ST_TDEC: walk_ff <= '0;
            psqrl_pkg::ST_TENT: begin
               if (rd_rate_ff == 16'd0) walk_ff <= walk_ff + 1'b1;
            end
            psqrl_pkg::ST_TAPP: begin
               if (!(ban && out_full)) begin
                  rate_ff[walk_ff] <= ban ? 16'd0 : decayed;
                  walk_ff          <= walk_ff + 1'b1;
               end
            end
            psqrl_pkg::ST_TFIN: begin
               glob_ff  <= (uniq_ff > cfg.unique_filter_max)
                        || (total_ff > cfg.total_filter_max);
               total_ff <= 16'd0;
               if (uniq_ff <= 16'(psqrl_pkg::FloorQ)) begin
                  uniq_ff <= 16'd0;
               end else if (uniq_ff > 16'(psqrl_pkg::Entries + psqrl_pkg::FloorQ)) begin
                  uniq_ff <= uniq_ff - 16'(psqrl_pkg::Entries);
               end else begin
                  uniq_ff <= 16'(psqrl_pkg::FloorQ);
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_rate_ff <= rate_ff[rd_idx];
      if (state_ff == psqrl_pkg::ST_IDLE && job_valid) job_ff <= job;
      if (state_ff == psqrl_pkg::ST_TINIT) prod_ff <= {16'd0, cfg.ban_level_pps} * {16'd0, deff};
      if (state_ff == psqrl_pkg::ST_TDEC) dec_ff <= dec_prod[psqrl_pkg::MsShift +: psqrl_pkg::DecW];
      case (state_ff)
         psqrl_pkg::ST_DISP: begin
            hit_ff   <= match_hit;
            hidx_ff  <= match_idx;
            allow_ff <= 1'b1;
            kind_ff  <= (job_ff.op == psqrl_pkg::CMD_CHECK) ? psqrl_pkg::KIND_VERDICT
                                                           : psqrl_pkg::KIND_STATUS;
            if (job_ff.op != psqrl_pkg::CMD_CHECK) allow_ff <= 1'b0;
         end
         psqrl_pkg::ST_UPD: begin
            if (hit_ff) begin
               if (job_ff.critical && rd_rate_ff < cfg.high_prio_rate_min) begin
                  allow_ff <= 1'b1;
               end else begin
                  allow_ff <= ((rd_rate_ff == psqrl_pkg::Sat16 ? rd_rate_ff
                               : rd_rate_ff + 16'd1)
                              <= (job_ff.critical ? cfg.high_prio_rate_max
                                                  : cfg.low_prio_rate_max));
               end
            end else begin
               allow_ff <= (uniq_ff < 16'(psqrl_pkg::Entries));
            end
         end
         default: ;
      endcase
   end

   // output queue
   assign out_full  = (ocnt_ff == 2'd2);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = oq_ff[ord_ff];
   assign do_opop   = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (out_push) owr_ff <= ~owr_ff;
         if (do_opop) ord_ff <= ~ord_ff;
         ocnt_ff <= ocnt_ff + {1'b0, out_push} - {1'b0, do_opop};
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) oq_ff[owr_ff] <= out_data;
   end

endmodule

// File: hw/rtl/per_source_query_rate_limiter_unit.sv
// Check: fetch, CAM compare, rate update and status, which carries the verdict; the
// next job waits for status. Count, other commands and checks with the limiter off
// skip the update. Tick: after the decay term each slot is read; a live slot runs the
// divider for its pps quotient and is updated; then status. A waiting ban notice
// holds the walk until the output queue has room. Reset (synchronous, active high)
// clears the table, counters and queue pointers and presets the registers.
module per_source_query_rate_limiter_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  psqrl_pkg::req_type req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output psqrl_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   psqrl_pkg::cfg_type cfg_ff;
   psqrl_pkg::job_type job;
   logic               job_valid, job_pop;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limiter_enable     <= 1'b1;
         cfg_ff.ban_time_s         <= 16'd0;
         cfg_ff.ban_level_pps      <= 16'd400;
         cfg_ff.low_prio_rate_max  <= 16'd10;
         cfg_ff.high_prio_rate_max <= 16'd20;
         cfg_ff.high_prio_rate_min <= 16'd5;
         cfg_ff.unique_filter_max  <= 16'd16;
         cfg_ff.total_filter_max   <= 16'd64;
      end else if (csr_write) begin
         case (csr_index)
            psqrl_pkg::REG_ENABLE:    cfg_ff.limiter_enable     <= csr_data[0];
            psqrl_pkg::REG_BAN_TIME:  cfg_ff.ban_time_s         <= csr_data;
            psqrl_pkg::REG_BAN_LEVEL: cfg_ff.ban_level_pps      <= csr_data;
            psqrl_pkg::REG_LP_MAX:    cfg_ff.low_prio_rate_max  <= csr_data;
            psqrl_pkg::REG_HP_MAX:    cfg_ff.high_prio_rate_max <= csr_data;
            psqrl_pkg::REG_HP_MIN:    cfg_ff.high_prio_rate_min <= csr_data;
            psqrl_pkg::REG_UNIQ_MAX:  cfg_ff.unique_filter_max  <= csr_data;
            psqrl_pkg::REG_TOTAL_MAX: cfg_ff.total_filter_max   <= csr_data;
            default: ;
         endcase
      end
   end

   psqrl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job)
   );

   psqrl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid) else $error("job taken from empty queue");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> !job_pop) else $error("back end took two jobs in a row");

   a_ban_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == psqrl_pkg::KIND_BAN) |-> (!rsp_data.last && !rsp_data.allow))
      else $error("ban notice marked last or allowed");

endmodule

// File: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 2000000;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   psqrl_pkg::req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   psqrl_pkg::rsp_type rsp_data;
   logic    csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   per_source_query_rate_limiter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Shadow copy of the limiter state and registers
   psqrl_pkg::cfg_type cfg;
   logic [31:0] addr_tab [psqrl_pkg::Entries];
   int          rate_tab [psqrl_pkg::Entries];
   int          ins_ptr;
   int          uniq_cnt;
   int          total_cnt;
   logic        gflag;

   psqrl_pkg::rsp_type expected_rsp_q [$];
   int          errors;
   int          items_sent;
   int          rsp_checked;
   int          bans_seen;
   int          send_idle_pct;
   int          pop_stall_pct;
   int          hold_left;
   longint      cycles;
   logic [31:0] ip_pool [6];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_rsp_q.size());
         $display("tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic void refresh_global();
      gflag = (uniq_cnt > int'(cfg.unique_filter_max)) ||
              (total_cnt > int'(cfg.total_filter_max));
   endfunction

   function automatic void push_status(logic [1:0] kind, logic allow);
      psqrl_pkg::rsp_type s;
      s = '0;
      s.kind            = kind;
      s.allow           = allow;
      s.global_limit    = gflag;
      s.under_flood     = (uniq_cnt >= psqrl_pkg::Entries);
      s.global_query_ok = (total_cnt < psqrl_pkg::Entries);
      s.last            = 1'b1;
      expected_rsp_q.push_back(s);
   endfunction

   function automatic logic lookup_query(logic [31:0] ip, logic crit);
      int lim;
      if (!cfg.limiter_enable) return 1'b1;
      for (int i = 0; i < psqrl_pkg::Entries; i++) begin
         if (addr_tab[i] != ip) continue;
         if (crit && rate_tab[i] < int'(cfg.high_prio_rate_min)) begin
            rate_tab[i] = cfg.high_prio_rate_min;
            return 1'b1;
         end
         if (rate_tab[i] < 65535) rate_tab[i]++;
         lim = crit ? int'(cfg.high_prio_rate_max) : int'(cfg.low_prio_rate_max);
         return rate_tab[i] <= lim;
      end
      if (uniq_cnt < 65535) uniq_cnt++;
      if (uniq_cnt > psqrl_pkg::Entries) begin
         refresh_global();
         return 1'b0;
      end
      ins_ptr = (ins_ptr + 1 >= psqrl_pkg::Entries) ? 0 : ins_ptr + 1;
      addr_tab[ins_ptr] = ip;
      rate_tab[ins_ptr] = 1;
      return 1'b1;
   endfunction

   function automatic void walk_table(logic [15:0] delta_ms);
      longint  d, pps, dec, nr, lo;
      int      lp, dcnt;
      psqrl_pkg::rsp_type b;
      d  = (delta_ms == 0) ? 1 : delta_ms;
      lp = cfg.low_prio_rate_max;
      for (int i = 0; i < psqrl_pkg::Entries; i++) begin
         if (rate_tab[i] == 0) continue;
         pps = (longint'(rate_tab[i]) * 1000) / d;
         if (cfg.ban_time_s != 0 && pps > longint'(cfg.ban_level_pps)) begin
            b         = '0;
            b.kind    = psqrl_pkg::KIND_BAN;
            b.ban_ip  = addr_tab[i];
            b.ban_pps = pps[25:0];
            expected_rsp_q.push_back(b);
            rate_tab[i] = 0;
            continue;
         end
         if (rate_tab[i] <= 2 * lp) begin
            rate_tab[i] = 0;
         end else begin
            dec = (longint'(cfg.ban_level_pps) * d) / 1000;
            nr  = rate_tab[i] - dec;
            lo  = lp / 2;
            rate_tab[i] = int'((nr > lo) ? nr : lo);
         end
      end
      refresh_global();
      total_cnt = 0;
      if (uniq_cnt <= psqrl_pkg::FloorQ) begin
         uniq_cnt = 0;
      end else begin
         dcnt = (uniq_cnt > psqrl_pkg::Entries) ? uniq_cnt - psqrl_pkg::Entries : 0;
         uniq_cnt = (dcnt > psqrl_pkg::FloorQ) ? dcnt : psqrl_pkg::FloorQ;
      end
      push_status(psqrl_pkg::KIND_STATUS, 1'b0);
   endfunction

   function automatic void predict_request(psqrl_pkg::req_type r);
      case (psqrl_pkg::cmd_type'(r.cmd))
         psqrl_pkg::CMD_CHECK:
            push_status(psqrl_pkg::KIND_VERDICT, lookup_query(r.src_ip, r.critical));
         psqrl_pkg::CMD_COUNT: begin
            if (total_cnt < 65535) total_cnt++;
            push_status(psqrl_pkg::KIND_STATUS, 1'b0);
         end
         psqrl_pkg::CMD_TICK:  walk_table(r.delta_ms);
         default:              push_status(psqrl_pkg::KIND_STATUS, 1'b0);
      endcase
   endfunction

   // ---------------------------------------------------------------- drivers
   // Offer one transaction, idling first at the configured rate
   task automatic send_request(psqrl_pkg::req_type r);
      logic f;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         f = req_full;
         @(posedge clock);
      end while (f);
      predict_request(r);
      items_sent++;
   endtask

   task automatic send_cmd(psqrl_pkg::cmd_type c, logic [31:0] ip, logic crit,
                           logic [15:0] dms);
      psqrl_pkg::req_type r;
      r.cmd      = c;
      r.src_ip   = ip;
      r.critical = crit;
      r.delta_ms = dms;
      send_request(r);
   endtask

   // Wait until every expected result has come back and the block has settled
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         psqrl_pkg::REG_ENABLE:    cfg.limiter_enable     = val[0];
         psqrl_pkg::REG_BAN_TIME:  cfg.ban_time_s         = val;
         psqrl_pkg::REG_BAN_LEVEL: cfg.ban_level_pps      = val;
         psqrl_pkg::REG_LP_MAX:    cfg.low_prio_rate_max  = val;
         psqrl_pkg::REG_HP_MAX:    cfg.high_prio_rate_max = val;
         psqrl_pkg::REG_HP_MIN:    cfg.high_prio_rate_min = val;
         psqrl_pkg::REG_UNIQ_MAX:  cfg.unique_filter_max  = val;
         psqrl_pkg::REG_TOTAL_MAX: cfg.total_filter_max   = val;
         default: ;
      endcase
   endtask

   // Pop results, stalling at random or holding off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop   <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // Compare each popped transaction with the oldest expectation
   always @(negedge clock) begin
      psqrl_pkg::rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
         end else begin
            e = expected_rsp_q.pop_front();
            rsp_checked++;
            if (e.kind == psqrl_pkg::KIND_BAN) bans_seen++;
            if (rsp_data !== e) begin
               errors++;
               if (errors <= 20) begin
                  if (rsp_data.kind !== e.kind)
                     $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_data.kind);
                  if (rsp_data.allow !== e.allow)
                     $display("%0t: allow expected %0d actual %0d", $time, e.allow,
                              rsp_data.allow);
                  if (rsp_data.ban_ip !== e.ban_ip)
                     $display("%0t: ban_ip expected %h actual %h", $time, e.ban_ip,
                              rsp_data.ban_ip);
                  if (rsp_data.ban_pps !== e.ban_pps)
                     $display("%0t: ban_pps expected %0d actual %0d", $time, e.ban_pps,
                              rsp_data.ban_pps);
                  if (rsp_data.global_limit !== e.global_limit)
                     $display("%0t: global_limit expected %0d actual %0d", $time,
                              e.global_limit, rsp_data.global_limit);
                  if (rsp_data.under_flood !== e.under_flood)
                     $display("%0t: under_flood expected %0d actual %0d", $time,
                              e.under_flood, rsp_data.under_flood);
                  if (rsp_data.global_query_ok !== e.global_query_ok)
                     $display("%0t: global_query_ok expected %0d actual %0d", $time,
                              e.global_query_ok, rsp_data.global_query_ok);
                  if (rsp_data.last !== e.last)
                     $display("%0t: last expected %0d actual %0d", $time, e.last,
                              rsp_data.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   function automatic logic [31:0] pick_ip();
      if ($urandom_range(99) < 75) return ip_pool[$urandom_range(5)];
      return $urandom;
   endfunction

   function automatic logic [15:0] pick_delta();
      case ($urandom_range(3))
         0:       return 16'($urandom_range(1, 20));
         1:       return 16'($urandom_range(20, 3000));
         2:       return 16'($urandom);
         default: return ($urandom_range(9) == 0) ? 16'd0 : 16'd1000;
      endcase
   endfunction

   task automatic send_random(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 75)
            send_cmd(psqrl_pkg::CMD_CHECK, pick_ip(), 1'($urandom_range(1)), 16'($urandom));
         else if (sel < 88)
            send_cmd(psqrl_pkg::CMD_COUNT, $urandom, 1'($urandom_range(1)), 16'($urandom));
         else if (sel < 96)
            send_cmd(psqrl_pkg::CMD_TICK, $urandom, 1'($urandom_range(1)), pick_delta());
         else
            send_cmd(psqrl_pkg::CMD_OTHER, $urandom, 1'($urandom_range(1)), 16'($urandom));
      end
   endtask

   // Edges of the fields, every command, address zero, zero delta
   task automatic test_directed();
      send_cmd(psqrl_pkg::CMD_CHECK, 32'h0, 1'b0, 16'h0);
      send_cmd(psqrl_pkg::CMD_CHECK, 32'h0, 1'b1, 16'hFFFF);
      send_cmd(psqrl_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 16'h0);
      for (int i = 0; i < 12; i++) send_cmd(psqrl_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b0, 16'h0);
      send_cmd(psqrl_pkg::CMD_CHECK, 32'hFFFF_FFFF, 1'b1, 16'h0);
      send_cmd(psqrl_pkg::CMD_COUNT, 32'h0, 1'b0, 16'h0);
      send_cmd(psqrl_pkg::CMD_OTHER, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
      send_cmd(psqrl_pkg::CMD_TICK, 32'h0, 1'b0, 16'h0);
      send_cmd(psqrl_pkg::CMD_TICK, 32'h0, 1'b0, 16'hFFFF);
      drain();
   endtask

   // Hammer a few sources, then tick with banning enabled
   task automatic test_ban();
      write_reg(psqrl_pkg::REG_BAN_TIME, 16'd30);
      write_reg(psqrl_pkg::REG_BAN_LEVEL, 16'd50);
      write_reg(psqrl_pkg::REG_LP_MAX, 16'd3);
      for (int i = 0; i < 20; i++) send_cmd(psqrl_pkg::CMD_CHECK, ip_pool[i % 3], i[0], 16'd0);
      send_cmd(psqrl_pkg::CMD_CHECK, ip_pool[4], 1'b0, 16'd0);
      send_cmd(psqrl_pkg::CMD_TICK, 32'h0, 1'b0, 16'd100);
      drain();
   endtask

   // Fill the table past its size to reach the refusal and flood flags
   task automatic test_flood();
      for (int i = 0; i < 40; i++) send_cmd(psqrl_pkg::CMD_CHECK, $urandom, 1'b0, 16'd0);
      for (int i = 0; i < 36; i++) send_cmd(psqrl_pkg::CMD_COUNT, 32'h0, 1'b0, 16'd0);
      send_cmd(psqrl_pkg::CMD_TICK, 32'h0, 1'b0, 16'd1000);
      drain();
   endtask

   // Hold off the receiver long enough for the block to back up its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_left     = 400;
      send_random(40);
      drain();
   endtask

   // Random traffic under one register setting per phase
   task automatic test_random_phase(int idle, int stall, int n);
      send_idle_pct = idle;
      pop_stall_pct = stall;
      send_random(n);
      drain();
   endtask

   task automatic test_settings();
      write_reg(psqrl_pkg::REG_ENABLE, 16'h0);
      test_random_phase(0, 0, 20);
      write_reg(psqrl_pkg::REG_ENABLE, 16'hFFFF);
      write_reg(psqrl_pkg::REG_BAN_TIME, 16'hFFFF);
      write_reg(psqrl_pkg::REG_BAN_LEVEL, 16'h0);
      write_reg(psqrl_pkg::REG_LP_MAX, 16'd1);
      write_reg(psqrl_pkg::REG_HP_MAX, 16'd1);
      write_reg(psqrl_pkg::REG_HP_MIN, 16'h0);
      write_reg(psqrl_pkg::REG_UNIQ_MAX, 16'h0);
      write_reg(psqrl_pkg::REG_TOTAL_MAX, 16'h0);
      test_random_phase(59, 0, 30);
      write_reg(psqrl_pkg::REG_BAN_TIME, 16'h0);
      write_reg(psqrl_pkg::REG_BAN_LEVEL, 16'hFFFF);
      write_reg(psqrl_pkg::REG_LP_MAX, 16'hFFFF);
      write_reg(psqrl_pkg::REG_HP_MAX, 16'hFFFF);
      write_reg(psqrl_pkg::REG_HP_MIN, 16'hFFFF);
      write_reg(psqrl_pkg::REG_UNIQ_MAX, 16'hFFFF);
      write_reg(psqrl_pkg::REG_TOTAL_MAX, 16'hFFFF);
      test_random_phase(0, 59, 30);
      write_reg(psqrl_pkg::REG_BAN_TIME, 16'd5);
      write_reg(psqrl_pkg::REG_BAN_LEVEL, 16'd400);
      write_reg(psqrl_pkg::REG_LP_MAX, 16'd4);
      write_reg(psqrl_pkg::REG_HP_MAX, 16'd8);
      write_reg(psqrl_pkg::REG_HP_MIN, 16'd3);
      write_reg(psqrl_pkg::REG_UNIQ_MAX, 16'd10);
      write_reg(psqrl_pkg::REG_TOTAL_MAX, 16'd20);
      test_random_phase(33, 33, 50);
      test_random_phase(0, 0, 30);
   endtask

   initial begin
      cycles        = 0;
      errors        = 0;
      items_sent    = 0;
      rsp_checked   = 0;
      bans_seen     = 0;
      send_idle_pct = 0;
      pop_stall_pct = 0;
      hold_left     = 0;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data      = '0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      ip_pool = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0101, 32'h0A00_0002, 32'h5555_AAAA,
                  32'hAAAA_5555};

      // Reset values of the shadow state
      cfg.limiter_enable     = 1'b1;
      cfg.ban_time_s         = 16'd0;
      cfg.ban_level_pps      = 16'd400;
      cfg.low_prio_rate_max  = 16'd10;
      cfg.high_prio_rate_max = 16'd20;
      cfg.high_prio_rate_min = 16'd5;
      cfg.unique_filter_max  = 16'd16;
      cfg.total_filter_max   = 16'd64;
      for (int i = 0; i < psqrl_pkg::Entries; i++) begin
         addr_tab[i] = '0;
         rate_tab[i] = 0;
      end
      ins_ptr   = psqrl_pkg::Entries - 1;
      uniq_cnt  = 0;
      total_cnt = 0;
      gflag     = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_ban();
      test_flood();
      test_backpressure();
      test_settings();

      $display("Sent %0d requests; checked %0d results, %0d of them ban notices,",
               items_sent, rsp_checked, bans_seen);
      $display("across enable off, extreme limits, flooding and receiver hold-off.");
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
